[design/trrcp_pkg.sv]
// shared types and constants of the two-level round-robin connection picker
// used by trrcp_ctrl, trrcp_dpath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package trrcp_pkg;

   localparam int DEF_MAX_SERVERS = 16;
   localparam int DEF_MAX_CONNS   = 16;

   localparam int IDX_W = 4;   // server and slot index fields
   localparam int CNT_W = 5;   // counts and rotation pointers
   localparam int ST_W  = 4;   // connection status bits

   // status bit positions
   localparam int ST_RESTRICTED = 0;
   localparam int ST_QFULL      = 1;
   localparam int ST_NIP        = 2;
   localparam int ST_ALIVE      = 3;

   typedef enum logic [1:0] {
      ACT_PICK_GROUP   = 2'd0,
      ACT_PICK_SERVER  = 2'd1,
      ACT_WRITE_STATUS = 2'd2,
      ACT_SET_COUNT    = 2'd3
   } action_type;

   typedef struct packed {
      logic load;
      logic write_status;
      logic set_count;
      logic init_group;
      logic init_one;
      logic srv_step;
      logic pass_group;
      logic pass_one;
      logic conn_step;
      logic eval;
      logic finish;
      logic hit;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      action_type action;
      logic       one_bad;
      logic       srv_done;
      logic       conn_done;
      logic       again;
      logic       hit;
      logic       out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[design/trrcp_dpath.sv]
// datapath of the connection picker: pointers, counts, status memory, result registers
// depends on trrcp_pkg; driven by trrcp_ctrl
`timescale 1ns / 1ps
`default_nettype none

module trrcp_dpath #(
   parameter int MAX_SERVERS = trrcp_pkg::DEF_MAX_SERVERS,
   parameter int MAX_CONNS   = trrcp_pkg::DEF_MAX_CONNS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire trrcp_pkg::dp_cmd_type          cmd,
   output trrcp_pkg::dp_status_type            status,
   input  wire logic                           csr_wr_en,
   input  wire logic [trrcp_pkg::CNT_W-1:0]    csr_wr_data,
   input  wire trrcp_pkg::action_type          in_action,
   input  wire logic [trrcp_pkg::IDX_W-1:0]    in_server,
   input  wire logic [trrcp_pkg::IDX_W-1:0]    in_conn,
   input  wire logic [trrcp_pkg::ST_W-1:0]     in_status,
   input  wire logic [trrcp_pkg::CNT_W-1:0]    in_count,
   input  wire logic                           out_ready,
   output logic                                out_valid,
   output logic                                out_found,
   output logic [trrcp_pkg::IDX_W-1:0]         out_server,
   output logic [trrcp_pkg::IDX_W-1:0]         out_conn
);
   import trrcp_pkg::*;

   // only slots an index field can reach hold state
   localparam int NumSrv   = (MAX_SERVERS < 2**IDX_W) ? MAX_SERVERS : 2**IDX_W;
   localparam int NumConn  = (MAX_CONNS < 2**IDX_W) ? MAX_CONNS : 2**IDX_W;
   localparam int SI_W     = (NumSrv > 1) ? $clog2(NumSrv) : 1;
   localparam int CI_W     = (NumConn > 1) ? $clog2(NumConn) : 1;
   localparam int AW       = SI_W + CI_W;
   localparam int MemDepth = 2**AW;

   logic [CNT_W-1:0] server_count_ff, server_count_in;
   logic [CNT_W-1:0] server_ptr_ff, server_ptr_in;
   logic [CNT_W-1:0] conn_ptr_ff [NumSrv];
   logic [CNT_W-1:0] conn_cnt_ff [NumSrv];
   logic [ST_W-1:0]  status_mem  [MemDepth];
   logic             valid_ff    [MemDepth];

   action_type       act_ff, act_in;
   logic [IDX_W-1:0] act_srv_ff, act_srv_in;
   logic [IDX_W-1:0] act_conn_ff, act_conn_in;
   logic [ST_W-1:0]  act_st_ff, act_st_in;
   logic [CNT_W-1:0] act_cnt_ff, act_cnt_in;

   logic [CNT_W-1:0] cur_srv_ff, cur_srv_in;
   logic [CNT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] ksrv_ff, ksrv_in;
   logic [CNT_W-1:0] kconn_ff, kconn_in;
   logic             pass_ff, pass_in;
   logic             nip_ff, nip_in;
   logic [ST_W-1:0]  mem_q_ff;
   logic             vld_q_ff;
   logic             slot_ok_ff, slot_ok_in;

   logic             res_found_ff, res_found_in;
   logic [IDX_W-1:0] res_srv_ff, res_srv_in;
   logic [IDX_W-1:0] res_conn_ff, res_conn_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0] rsp_srv_ff, rsp_srv_in;
   logic [IDX_W-1:0] rsp_conn_ff, rsp_conn_in;

   logic             cur_ok;
   logic [SI_W-1:0]  cur_sel;
   logic [CNT_W-1:0] cur_cnt;
   logic [CNT_W-1:0] cur_ptr;
   logic [CNT_W:0]   c_inc;
   logic [CNT_W-1:0] adv_c;
   logic [CNT_W:0]   s_inc;
   logic [CNT_W-1:0] adv_s;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;
   logic             wr_srv_ok;
   logic             wr_conn_ok;
   logic [CNT_W-1:0] cnt_capped;
   logic [ST_W-1:0]  st_eff;
   logic             blocked;
   logic             nip_skip;

   always_comb begin
      cur_ok  = int'(cur_srv_ff) < NumSrv;
      cur_sel = cur_srv_ff[SI_W-1:0];
      cur_cnt = cur_ok ? conn_cnt_ff[cur_sel] : '0;
      cur_ptr = cur_ok ? conn_ptr_ff[cur_sel] : '0;
      c_inc   = {1'b0, cur_ptr} + 1'b1;
      adv_c   = (c_inc >= {1'b0, cur_cnt}) ? '0 : c_inc[CNT_W-1:0];
      s_inc   = {1'b0, server_ptr_ff} + 1'b1;
      adv_s   = (s_inc >= {1'b0, server_count_ff}) ? '0 : s_inc[CNT_W-1:0];
      rd_addr = {cur_sel, adv_c[CI_W-1:0]};
      wr_addr = {act_srv_ff[SI_W-1:0], act_conn_ff[CI_W-1:0]};
      wr_srv_ok  = int'(act_srv_ff) < NumSrv;
      wr_conn_ok = int'(act_conn_ff) < NumConn;
      cnt_capped = (int'(act_cnt_ff) > MAX_CONNS) ? CNT_W'(MAX_CONNS) : act_cnt_ff;
      st_eff   = (vld_q_ff && slot_ok_ff) ? mem_q_ff : '0;
      blocked  = st_eff[ST_RESTRICTED] | st_eff[ST_QFULL];
      nip_skip = !pass_ff && st_eff[ST_NIP];
   end

   always_comb begin
      status.action    = act_ff;
      status.one_bad   = {1'b0, act_srv_ff} >= server_count_ff;
      status.srv_done  = ksrv_ff == server_count_ff;
      status.conn_done = kconn_ff == cur_cnt;
      status.again     = !pass_ff && nip_ff;
      status.hit       = !blocked && !nip_skip && st_eff[ST_ALIVE];
      status.out_free  = !rsp_valid_ff || out_ready;
   end

   always_comb begin
      server_count_in = server_count_ff;
      if (csr_wr_en) begin
         server_count_in = (int'(csr_wr_data) > MAX_SERVERS) ?
                           CNT_W'(MAX_SERVERS) : csr_wr_data;
      end

      act_in      = act_ff;
      act_srv_in  = act_srv_ff;
      act_conn_in = act_conn_ff;
      act_st_in   = act_st_ff;
      act_cnt_in  = act_cnt_ff;
      if (cmd.load) begin
         act_in      = in_action;
         act_srv_in  = in_server;
         act_conn_in = in_conn;
         act_st_in   = in_status;
         act_cnt_in  = in_count;
      end

      server_ptr_in = server_ptr_ff;
      cur_srv_in    = cur_srv_ff;
      slot_in       = slot_ff;
      slot_ok_in    = slot_ok_ff;
      ksrv_in       = ksrv_ff;
      kconn_in      = kconn_ff;
      pass_in       = pass_ff;
      nip_in        = nip_ff;
      if (cmd.init_group) begin
         ksrv_in = '0;
         pass_in = 1'b0;
         nip_in  = 1'b0;
      end
      if (cmd.init_one) begin
         cur_srv_in = {1'b0, act_srv_ff};
         kconn_in   = '0;
         pass_in    = 1'b0;
         nip_in     = 1'b0;
      end
      if (cmd.srv_step) begin
         server_ptr_in = adv_s;
         cur_srv_in    = adv_s;
         ksrv_in       = ksrv_ff + 1'b1;
         kconn_in      = '0;
      end
      if (cmd.pass_group) begin
         pass_in = 1'b1;
         ksrv_in = '0;
      end
      if (cmd.pass_one) begin
         pass_in  = 1'b1;
         kconn_in = '0;
      end
      if (cmd.conn_step) begin
         slot_in    = adv_c;
         slot_ok_in = int'(adv_c) < NumConn;
         kconn_in   = kconn_ff + 1'b1;
      end
      if (cmd.eval && !blocked && nip_skip && st_eff[ST_ALIVE]) begin
         nip_in = 1'b1;
      end

      res_found_in = res_found_ff;
      res_srv_in   = res_srv_ff;
      res_conn_in  = res_conn_ff;
      if (cmd.finish) begin
         res_found_in = cmd.hit;
         res_srv_in   = cmd.hit ? cur_srv_ff[IDX_W-1:0] : '0;
         res_conn_in  = cmd.hit ? slot_ff[IDX_W-1:0] : '0;
      end

      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_found_in = rsp_found_ff;
      rsp_srv_in   = rsp_srv_ff;
      rsp_conn_in  = rsp_conn_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res_found_ff;
         rsp_srv_in   = res_srv_ff;
         rsp_conn_in  = res_conn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         server_count_ff <= '0;
         server_ptr_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         server_count_ff <= server_count_in;
         server_ptr_ff   <= server_ptr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      act_srv_ff   <= act_srv_in;
      act_conn_ff  <= act_conn_in;
      act_st_ff    <= act_st_in;
      act_cnt_ff   <= act_cnt_in;
      cur_srv_ff   <= cur_srv_in;
      slot_ff      <= slot_in;
      slot_ok_ff   <= slot_ok_in;
      ksrv_ff      <= ksrv_in;
      kconn_ff     <= kconn_in;
      pass_ff      <= pass_in;
      nip_ff       <= nip_in;
      res_found_ff <= res_found_in;
      res_srv_ff   <= res_srv_in;
      res_conn_ff  <= res_conn_in;
      rsp_found_ff <= rsp_found_in;
      rsp_srv_ff   <= rsp_srv_in;
      rsp_conn_ff  <= rsp_conn_in;
   end

   // per-server slot pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSrv; i++) begin
            conn_ptr_ff[i] <= '0;
            conn_cnt_ff[i] <= '0;
         end
      end else begin
         if (cmd.set_count && wr_srv_ok) begin
            conn_cnt_ff[act_srv_ff[SI_W-1:0]] <= cnt_capped;
            conn_ptr_ff[act_srv_ff[SI_W-1:0]] <= '0;
         end
         if (cmd.conn_step && cur_ok) begin
            conn_ptr_ff[cur_sel] <= adv_c;
         end
      end
   end

   // valid bits: an unwritten entry reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MemDepth; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.write_status && wr_srv_ok && wr_conn_ok) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      vld_q_ff <= valid_ff[rd_addr];
   end

   // connection status memory
   always_ff @(posedge clock) begin
      if (cmd.write_status && wr_srv_ok && wr_conn_ok) begin
         status_mem[wr_addr] <= act_st_ff;
      end
      mem_q_ff <= status_mem[rd_addr];
   end

   assign out_valid  = rsp_valid_ff;
   assign out_found  = rsp_found_ff;
   assign out_server = rsp_srv_ff;
   assign out_conn   = rsp_conn_ff;

endmodule

`default_nettype wire

[design/trrcp_ctrl.sv]
// sequencing state machine of the connection picker
// depends on trrcp_pkg; commands trrcp_dpath
`timescale 1ns / 1ps
`default_nettype none

module trrcp_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire trrcp_pkg::dp_status_type status,
   output trrcp_pkg::dp_cmd_type         cmd
);
   import trrcp_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_DECODE    = 6'b000010,
      S_SRV_STEP  = 6'b000100,
      S_CONN_STEP = 6'b001000,
      S_EVAL      = 6'b010000,
      S_DONE      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.action)
               ACT_PICK_GROUP: begin
                  cmd.init_group = 1'b1;
                  state_in       = S_SRV_STEP;
               end
               ACT_PICK_SERVER: begin
                  if (status.one_bad) begin
                     cmd.finish = 1'b1;
                     state_in   = S_DONE;
                  end else begin
                     cmd.init_one = 1'b1;
                     state_in     = S_CONN_STEP;
                  end
               end
               ACT_WRITE_STATUS: begin
                  cmd.write_status = 1'b1;
                  cmd.finish       = 1'b1;
                  state_in         = S_DONE;
               end
               ACT_SET_COUNT: begin
                  cmd.set_count = 1'b1;
                  cmd.finish    = 1'b1;
                  state_in      = S_DONE;
               end
            endcase
         end
         S_SRV_STEP: begin
            if (!status.srv_done) begin
               cmd.srv_step = 1'b1;
               state_in     = S_CONN_STEP;
            end else if (status.again) begin
               cmd.pass_group = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_CONN_STEP: begin
            if (!status.conn_done) begin
               cmd.conn_step = 1'b1;
               state_in      = S_EVAL;
            end else if (status.action == ACT_PICK_GROUP) begin
               state_in = S_SRV_STEP;
            end else if (status.again) begin
               cmd.pass_one = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (status.hit) begin
               cmd.finish = 1'b1;
               cmd.hit    = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_CONN_STEP;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/two_level_round_robin_conn_picker.sv]
// Two-level round-robin connection picker.
// One request beat on req_* carries an action in req_tuser. A group pick
// rotates over the servers and, inside each, over its connection slots,
// skipping restricted and queue-full slots; a first pass also skips slots
// holding a non-idempotent request and reruns without that skip if any such
// slot was live. A server pick does the same inside one server. Writes set
// a slot's status bits or a server's slot count (clearing its slot pointer).
// Every request beat yields exactly one response beat on rsp_*.
// A pick probes slots in turn, each by a memory read and then an evaluate
// step, and passes through a server step for each server entered or left
// without a hit. req_tready rises in the same cycle as rsp_tvalid.
// One request is worked on at a time; req_tready is high only when the
// sequencer is idle. A finished response waits in the output register
// while the next request is accepted; a stalled rsp_tready holds that
// response and stops the sequencer only once its next result is ready.
// Reset clears the server count, all pointers, counts and slot status.
// csr_wr_en writes the server count; keep it to idle cycles (not enforced).
// depends on trrcp_pkg, trrcp_ctrl and trrcp_dpath
`timescale 1ns / 1ps
`default_nettype none

module two_level_round_robin_conn_picker #(
   parameter int MAX_SERVERS = trrcp_pkg::DEF_MAX_SERVERS,
   parameter int MAX_CONNS   = trrcp_pkg::DEF_MAX_CONNS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // server_index[3:0], conn_index[7:4], restricted[8], queue_full[9],
   // holds_nonidempotent[10], alive[11], new_conn_count[16:12], zero pad
   input  wire logic [23:0]                 req_tdata,
   // action[1:0]
   input  wire logic [1:0]                  req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // chosen_server[3:0], chosen_conn[7:4]
   output logic [7:0]                       rsp_tdata,
   // found[0]
   output logic                             rsp_tuser,
   input  wire logic                        csr_wr_en,
   input  wire logic [trrcp_pkg::CNT_W-1:0] csr_wr_data
);
   import trrcp_pkg::*;

   dp_cmd_type       cmd;
   dp_status_type    status;
   logic [IDX_W-1:0] out_server;
   logic [IDX_W-1:0] out_conn;

   trrcp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   trrcp_dpath #(
      .MAX_SERVERS (MAX_SERVERS),
      .MAX_CONNS   (MAX_CONNS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_action   (action_type'(req_tuser)),
      .in_server   (req_tdata[3:0]),
      .in_conn     (req_tdata[7:4]),
      .in_status   (req_tdata[11:8]),
      .in_count    (req_tdata[16:12]),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_found   (rsp_tuser),
      .out_server  (out_server),
      .out_conn    (out_conn)
   );

   assign rsp_tdata = {out_conn, out_server};

endmodule

`default_nettype wire
